### rtl/bmd_pkg.sv
package bmd_pkg;

  // Fixed field and storage widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned HIST_BINS  = 256;
  localparam int unsigned HIST_AW    = 8;
  localparam int unsigned HIST_CNT_W = 23;
  localparam int unsigned BSUM_W     = 18;
  localparam int unsigned TOT_W      = 30;
  localparam int unsigned SQS_W      = 38;
  localparam int unsigned NPIX_W     = 25;
  localparam int unsigned B4_W       = 25;
  localparam int unsigned FBB_W      = 20;
  localparam int unsigned QIDX_W     = 13;

  localparam logic [BSUM_W-1:0] BSUM_CAP = 18'h3FFFF;
  localparam logic [14:0]       SQ_CAP   = 15'h7FFF;

  // Shift-add multiplier shape
  localparam int unsigned MUL_A_W = 40;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = 72;

  // Default capacities
  localparam int unsigned DEF_MAX_BLOCKS = 8192;
  localparam int unsigned DEF_MAX_PIXELS = 4194304;

  // Register reset values
  localparam logic [6:0] RST_BLOCK_SIZE    = 7'd16;
  localparam logic [8:0] RST_BLOCKS_ACROSS = 9'd40;
  localparam logic [8:0] RST_BLOCKS_DOWN   = 9'd30;
  localparam logic [7:0] RST_MOTION_FLOOR  = 8'd10;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE    = 2'd0,
    REG_BLOCKS_ACROSS = 2'd1,
    REG_BLOCKS_DOWN   = 2'd2,
    REG_MOTION_FLOOR  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_STATS = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] p;
  } mul_rsp_t;

endpackage

### rtl/block_motion_mask_detector.sv
// Block motion mask detector. Pixel pairs (previous, current) enter in raster order over a
// frame of blocks_across*block_size by blocks_down*block_size pixels; the clipped difference
// feeds a 256-bin histogram, a running total and one sum per block. After the last pixel the
// histogram is walked and one frame statistics result (total, sum of saturated squared
// rounded deviations from the mean) is emitted. A query returns the block's sum and a moving
// flag. A pixel passes through accept, memory read and read-modify-write. The end of frame
// walk visits every bin; an occupied bin also runs the bit-serial shift-add multiplier
// (one cycle per multiplier bit) and an 8-step restoring divider. A query on valid
// statistics with an in-range block runs three serial multiplies. After any register
// write the geometry is recomputed in S_GEO1 and S_GEO2 with the input held off. The
// histogram is cleared by valid bits, so no clearing sweep is run; block sums need none.
module block_motion_mask_detector #(
  parameter int unsigned MAX_BLOCKS = bmd_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned MAX_PIXELS = bmd_pkg::DEF_MAX_PIXELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // previous_pixel[7:0], current_pixel[15:8], block_index[28:16], zero[31:29]
  input  logic [31:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // difference_total[29:0], deviation_square_sum[66:30], block_total[84:67],
  // moving[85], size_error[86], zero[87]
  output logic [87:0] m_axis_tdata,
  // kind[0]
  output logic [0:0]  m_axis_tuser
);

  import bmd_pkg::*;

  localparam int unsigned BS_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef enum logic [4:0] {
    S_GEO1, S_GEO2, S_IDLE, S_PRD, S_PWR,
    S_WRD, S_WCNT, S_WVN, S_WDIV, S_WRND, S_WSQ, S_WCS,
    S_QRD, S_QS, S_QM1, S_QM2, S_QM3, S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [6:0] bsize_q;
  logic [8:0] across_q, down_q;
  logic [7:0] floor_q;

  // Derived geometry
  logic [17:0]       blocks_q;
  logic [13:0]       bb_q;
  logic [NPIX_W-1:0] npix_q;
  logic [B4_W-1:0]   b4_q;
  logic [FBB_W-1:0]  floor_bb_q;
  logic              bad_q;
  logic              range_bad;
  logic [31:0]       npix_full;
  logic [27:0]       b4_full;
  logic [21:0]       fbb_full;

  // Frame position and totals
  logic [5:0]           cib_q, rib_q;
  logic [7:0]           bcol_q, brow_q;
  logic [15:0]          rbase_q;
  logic [TOT_W-1:0]     tot_q, ftot_q;
  logic [SQS_W-1:0]     fsq_q, sacc_q;
  logic                 stats_q;
  logic [HIST_BINS-1:0] hvalid_q;

  // Work registers
  logic [PIX_W-1:0]      d_q;
  logic [QIDX_W-1:0]     qidx_q;
  logic [7:0]            v_q;
  logic [HIST_CNT_W-1:0] cnt_q;
  logic [36:0]           rem_q;
  logic [7:0]            quo_q;
  logic [2:0]            dstep_q;
  logic [BSUM_W-1:0]     s_q;
  logic [MUL_P_W-1:0]    lhs_q;

  // Pending result and output register
  logic              res_kind_q, res_mov_q, res_err_q;
  logic [BSUM_W-1:0] res_blk_q;
  logic              out_valid_q;
  logic [87:0]       out_data_q;
  logic              out_kind_q;

  // Memories
  logic                  hist_we;
  logic [HIST_AW-1:0]    hist_raddr;
  logic [HIST_CNT_W-1:0] hist_rdata, hist_new;
  logic                  bs_we;
  logic [16:0]           bs_raddr_full;
  logic [BSUM_W-1:0]     bs_rdata, bs_sat;
  logic [18:0]           bs_sum;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // Pixel path helpers
  logic [16:0] px_idx;
  logic        idx_ok, first_px;
  logic        col_last, bcol_last, rib_last, brow_last, frame_last;
  logic        accept;
  logic        emit_go;

  // Walk helpers
  logic [36:0] num, dev_abs, dsor;
  logic [8:0]  q9;
  logic        round_up;
  logic [14:0] sq15;
  logic [SQS_W-1:0] sacc_next;
  logic        q_out_range;

  assign range_bad = (bsize_q == 7'd0) || (bsize_q > 7'd64) ||
                     (across_q == 9'd0) || (across_q > 9'd256) ||
                     (down_q == 9'd0) || (down_q > 9'd256);
  assign npix_full = 32'(blocks_q) * 32'(bb_q);
  assign b4_full   = 28'(bb_q) * 28'(bb_q);
  assign fbb_full  = 22'(floor_q) * 22'(bb_q);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign first_px = (cib_q == 6'd0) && (rib_q == 6'd0);
  assign px_idx   = 17'(rbase_q) + 17'(bcol_q);
  assign idx_ok   = px_idx < 17'(MAX_BLOCKS);

  assign col_last   = {1'b0, cib_q} == (bsize_q - 7'd1);
  assign bcol_last  = {1'b0, bcol_q} == (across_q - 9'd1);
  assign rib_last   = {1'b0, rib_q} == (bsize_q - 7'd1);
  assign brow_last  = {1'b0, brow_q} == (down_q - 9'd1);
  assign frame_last = col_last && bcol_last && rib_last && brow_last;

  assign hist_new = hvalid_q[d_q] ? hist_rdata + 23'd1 : 23'd1;
  assign bs_sum   = first_px ? 19'(d_q) : {1'b0, bs_rdata} + 19'(d_q);
  assign bs_sat   = (bs_sum > 19'(BSUM_CAP)) ? BSUM_CAP : bs_sum[BSUM_W-1:0];

  assign hist_we       = (state_q == S_PWR);
  assign hist_raddr    = (state_q == S_WRD) ? v_q : d_q;
  assign bs_we         = (state_q == S_PWR) && idx_ok;
  assign bs_raddr_full = (state_q == S_QRD) ? 17'(qidx_q) : px_idx;

  assign num       = mul_rsp.p[36:0];
  assign dev_abs   = (num >= 37'(tot_q)) ? num - 37'(tot_q) : 37'(tot_q) - num;
  assign dsor      = 37'(npix_q) << dstep_q;
  assign round_up  = ({rem_q, 1'b0} > 38'(npix_q)) ||
                     (({rem_q, 1'b0} == 38'(npix_q)) && quo_q[0]);
  assign q9        = {1'b0, quo_q} + 9'(round_up);
  assign sq15      = (mul_rsp.p > MUL_P_W'(SQ_CAP)) ? SQ_CAP : mul_rsp.p[14:0];
  assign sacc_next = sacc_q + mul_rsp.p[SQS_W-1:0];

  assign q_out_range = (14'(qidx_q) >= blocks_q[13:0] && blocks_q[17:14] == 4'd0) ||
                       (17'(qidx_q) >= 17'(MAX_BLOCKS));

  assign emit_go = !out_valid_q || m_axis_tready;

  bmd_ram #(.WIDTH(HIST_CNT_W), .DEPTH(HIST_BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (d_q),
    .wdata_i (hist_new),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  bmd_ram #(.WIDTH(BSUM_W), .DEPTH(MAX_BLOCKS)) u_bsum (
    .clk_i   (clk_i),
    .we_i    (bs_we),
    .waddr_i (px_idx[BS_AW-1:0]),
    .wdata_i (bs_sat),
    .raddr_i (bs_raddr_full[BS_AW-1:0]),
    .rdata_o (bs_rdata)
  );

  bmd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Multiplier requests and next state
  always_comb begin
    mul_req = '0;
    state_d = state_q;
    case (state_q)
      S_GEO1: state_d = S_GEO2;
      S_GEO2: state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0] == CMD_QUERY) begin
            state_d = S_QRD;
          end else if (!bad_q) begin
            state_d = S_PRD;
          end
        end
      end
      S_PRD: state_d = S_PWR;
      S_PWR: state_d = frame_last ? S_WRD : S_IDLE;
      S_WRD: state_d = S_WCNT;
      S_WCNT: begin
        if (hvalid_q[v_q] && hist_rdata != '0) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(v_q);
          mul_req.b     = MUL_B_W'(npix_q);
          state_d       = S_WVN;
        end else begin
          state_d = (v_q == 8'hFF) ? S_EMIT : S_WRD;
        end
      end
      S_WVN: if (mul_rsp.done) state_d = S_WDIV;
      S_WDIV: if (dstep_q == 3'd0) state_d = S_WRND;
      S_WRND: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(q9);
        mul_req.b     = MUL_B_W'(q9);
        state_d       = S_WSQ;
      end
      S_WSQ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(cnt_q);
          mul_req.b     = MUL_B_W'(sq15);
          state_d       = S_WCS;
        end
      end
      S_WCS: if (mul_rsp.done) state_d = (v_q == 8'hFF) ? S_EMIT : S_WRD;
      S_QRD: state_d = (bad_q || !stats_q || q_out_range) ? S_EMIT : S_QS;
      S_QS: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(bs_rdata);
        mul_req.b     = MUL_B_W'(bs_rdata);
        state_d       = S_QM1;
      end
      S_QM1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.p[MUL_A_W-1:0];
          mul_req.b     = MUL_B_W'(npix_q);
          state_d       = S_QM2;
        end
      end
      S_QM2: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(fsq_q);
          mul_req.b     = MUL_B_W'(b4_q);
          state_d       = S_QM3;
        end
      end
      S_QM3: if (mul_rsp.done) state_d = S_EMIT;
      S_EMIT: if (emit_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // A register write restarts the frame and the geometry.
    if (cfg_we_i) begin
      state_d = S_GEO1;
    end
  end

  // Sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_GEO1;
      bsize_q     <= RST_BLOCK_SIZE;
      across_q    <= RST_BLOCKS_ACROSS;
      down_q      <= RST_BLOCKS_DOWN;
      floor_q     <= RST_MOTION_FLOOR;
      cib_q       <= '0;
      rib_q       <= '0;
      bcol_q      <= '0;
      brow_q      <= '0;
      rbase_q     <= '0;
      tot_q       <= '0;
      ftot_q      <= '0;
      fsq_q       <= '0;
      stats_q     <= 1'b0;
      hvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Drop the result once taken; S_EMIT may reload it the same cycle.
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_PWR: begin
          hvalid_q[d_q] <= 1'b1;
          tot_q         <= tot_q + TOT_W'(d_q);
          // Advance the raster position: column in block, block column, row in block, block row.
          if (col_last) begin
            cib_q <= '0;
            if (bcol_last) begin
              bcol_q <= '0;
              if (rib_last) begin
                rib_q <= '0;
                if (brow_last) begin
                  brow_q  <= '0;
                  rbase_q <= '0;
                end else begin
                  brow_q  <= brow_q + 8'd1;
                  rbase_q <= rbase_q + 16'(across_q);
                end
              end else begin
                rib_q <= rib_q + 6'd1;
              end
            end else begin
              bcol_q <= bcol_q + 8'd1;
            end
          end else begin
            cib_q <= cib_q + 6'd1;
          end
        end
        S_WCNT: begin
          if (!(hvalid_q[v_q] && hist_rdata != '0) && v_q == 8'hFF) begin
            ftot_q   <= tot_q;
            fsq_q    <= sacc_q;
            stats_q  <= 1'b1;
            tot_q    <= '0;
            hvalid_q <= '0;
          end
        end
        S_WCS: begin
          if (mul_rsp.done && v_q == 8'hFF) begin
            ftot_q   <= tot_q;
            fsq_q    <= sacc_next;
            stats_q  <= 1'b1;
            tot_q    <= '0;
            hvalid_q <= '0;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_BLOCK_SIZE:    bsize_q  <= cfg_data_i[6:0];
          REG_BLOCKS_ACROSS: across_q <= cfg_data_i;
          REG_BLOCKS_DOWN:   down_q   <= cfg_data_i;
          REG_MOTION_FLOOR:  floor_q  <= cfg_data_i[7:0];
          default: ;
        endcase
        cib_q    <= '0;
        rib_q    <= '0;
        bcol_q   <= '0;
        brow_q   <= '0;
        rbase_q  <= '0;
        tot_q    <= '0;
        stats_q  <= 1'b0;
        hvalid_q <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_GEO1: begin
        blocks_q <= 18'(across_q) * 18'(down_q);
        bb_q     <= 14'(bsize_q) * 14'(bsize_q);
      end
      S_GEO2: begin
        npix_q     <= npix_full[NPIX_W-1:0];
        b4_q       <= b4_full[B4_W-1:0];
        floor_bb_q <= fbb_full[FBB_W-1:0];
        bad_q      <= range_bad || (32'(blocks_q) > 32'(MAX_BLOCKS)) ||
                      (npix_full > 32'(MAX_PIXELS));
      end
      S_IDLE: begin
        d_q    <= (s_axis_tdata[15:8] > s_axis_tdata[7:0]) ?
                  s_axis_tdata[15:8] - s_axis_tdata[7:0] : '0;
        qidx_q <= s_axis_tdata[28:16];
      end
      S_PWR: begin
        v_q    <= '0;
        sacc_q <= '0;
      end
      S_WCNT: begin
        cnt_q <= hist_rdata;
        if (!(hvalid_q[v_q] && hist_rdata != '0)) begin
          v_q <= v_q + 8'd1;
          if (v_q == 8'hFF) begin
            res_kind_q <= KIND_STATS;
            res_blk_q  <= '0;
            res_mov_q  <= 1'b0;
            res_err_q  <= 1'b0;
          end
        end
      end
      S_WVN: begin
        rem_q   <= dev_abs;
        quo_q   <= '0;
        dstep_q <= 3'd7;
      end
      S_WDIV: begin
        if (rem_q >= dsor) begin
          rem_q          <= rem_q - dsor;
          quo_q[dstep_q] <= 1'b1;
        end
        dstep_q <= dstep_q - 3'd1;
      end
      S_WCS: begin
        if (mul_rsp.done) begin
          sacc_q <= sacc_next;
          v_q    <= v_q + 8'd1;
          if (v_q == 8'hFF) begin
            res_kind_q <= KIND_STATS;
            res_blk_q  <= '0;
            res_mov_q  <= 1'b0;
            res_err_q  <= 1'b0;
          end
        end
      end
      S_QRD: begin
        res_kind_q <= KIND_QUERY;
        res_blk_q  <= '0;
        res_mov_q  <= 1'b0;
        res_err_q  <= bad_q;
      end
      S_QS: s_q <= bs_rdata;
      S_QM2: if (mul_rsp.done) lhs_q <= mul_rsp.p;
      S_QM3: begin
        if (mul_rsp.done) begin
          res_blk_q <= s_q;
          res_mov_q <= !(lhs_q < mul_rsp.p) && !(20'(s_q) < floor_bb_q);
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_kind_q <= res_kind_q;
          out_data_q <= {1'b0, res_err_q, res_mov_q, res_blk_q,
                         stats_q ? fsq_q[36:0] : 37'd0,
                         stats_q ? ftot_q : 30'd0};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // The serial multiplier is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // Statistics become valid only on the way to emitting a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stats_q) |-> (state_q == S_EMIT))
    else $error("statistics valid without a pending result");

  // A register write holds off input while the geometry is rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input accepted right after a register write");

endmodule

### rtl/bmd_ram.sv
module bmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/bmd_mul.sv
module bmd_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmd_pkg::mul_req_t  req_i,
  output bmd_pkg::mul_rsp_t  rsp_o
);

  import bmd_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [MUL_P_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] acc_q;

  // One multiplier bit per cycle; stop once no set bits remain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if ((b_q >> 1) == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= MUL_P_W'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (b_q[0] ? a_q : '0);
      a_q   <= a_q << 1;
      b_q   <= b_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule
